@@ rtl/cplim_pkg.sv @@
// Shared types and constants for the per-client connection limiter.
`default_nettype none

package cplim_pkg;

	localparam int ADDR_W     = 32;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONN      = 1'b1;

	typedef enum logic {
		KIND_OPEN  = 1'b0,
		KIND_CLOSE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_OVER_LIMIT = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_NO_COUNT   = 2'd3
	} status_t;

	// What the table reports for the current key.
	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] count;
		logic             free_avail;
	} lookup_t;

	// How the table changes at the end of the current transfer.
	typedef struct packed {
		logic             wr;
		logic             alloc;
		logic [CNT_W-1:0] count;
	} update_t;

endpackage

`default_nettype wire

@@ rtl/cplim_table.sv @@
// Associative table of client addresses and live connection counts.
`default_nettype none

module cplim_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [cplim_pkg::ADDR_W-1:0] key,
	input  wire cplim_pkg::update_t           upd,
	output cplim_pkg::lookup_t                look
);

	logic [cplim_pkg::ADDR_W-1:0] entry_addr_q  [TABLE_ENTRIES];
	logic [cplim_pkg::CNT_W-1:0]  entry_count_q [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [TABLE_ENTRIES-1:0] free_vec;
	logic [TABLE_ENTRIES-1:0] free_sel;
	logic [cplim_pkg::CNT_W-1:0] hit_count;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			free_vec[i] = (entry_count_q[i] == '0);
			hit_vec[i]  = !free_vec[i] && (entry_addr_q[i] == key);
		end
	end

	// Lowest free slot as a one-hot vector.
	assign free_sel = free_vec & ((~free_vec) + TABLE_ENTRIES'(1));

	// At most one live slot holds a given address, so an OR works as the mux.
	always_comb begin
		hit_count = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit_vec[i]) begin
				hit_count = hit_count | entry_count_q[i];
			end
		end
	end

	assign look.hit        = |hit_vec;
	assign look.count      = hit_count;
	assign look.free_avail = |free_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				entry_count_q[i] <= '0;
			end
		end else if (upd.wr) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (upd.alloc ? free_sel[i] : hit_vec[i]) begin
					entry_count_q[i] <= upd.count;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.wr && upd.alloc) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (free_sel[i]) begin
					entry_addr_q[i] <= key;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/cplim_decide.sv @@
// Open and close decision: acceptance, status and the new count for one event.
`default_nettype none

module cplim_decide (
	input  wire logic                        fire,
	input  wire logic                        kind,
	input  wire logic                        limit_enabled,
	input  wire logic [cplim_pkg::CNT_W-1:0] conn_limit,
	input  wire cplim_pkg::lookup_t          look,
	output cplim_pkg::update_t               upd,
	output logic                             accepted,
	output cplim_pkg::status_t               status,
	output logic [cplim_pkg::CNT_W-1:0]      live_count
);

	logic [cplim_pkg::CNT_W-1:0] old_count;
	logic [cplim_pkg::CNT_W-1:0] inc_count;

	// A new address starts from zero in a free slot.
	assign old_count = look.hit ? look.count : '0;
	assign inc_count = (old_count == cplim_pkg::COUNT_MAX) ? cplim_pkg::COUNT_MAX
		: old_count + 16'd1;

	always_comb begin
		upd        = '0;
		accepted   = 1'b0;
		status     = cplim_pkg::ST_OK;
		live_count = '0;
		if (cplim_pkg::kind_t'(kind) == cplim_pkg::KIND_OPEN) begin
			if (!limit_enabled) begin
				accepted   = 1'b1;
				live_count = old_count;
			end else if (!look.hit && !look.free_avail) begin
				status = cplim_pkg::ST_TABLE_FULL;
			end else begin
				accepted   = (old_count < conn_limit);
				status     = accepted ? cplim_pkg::ST_OK : cplim_pkg::ST_OVER_LIMIT;
				live_count = inc_count;
				upd.wr     = fire;
				upd.alloc  = !look.hit;
				upd.count  = inc_count;
			end
		end else begin
			if (look.hit) begin
				live_count = look.count - 16'd1;
				upd.wr     = fire;
				upd.count  = look.count - 16'd1;
			end else begin
				status = cplim_pkg::ST_NO_COUNT;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/per_client_connection_limiter_top.sv @@
// Top level of the per-client connection limiter.
`default_nettype none

// Tracks live connections per client IPv4 address in a table of TABLE_ENTRIES
// slots and decides on each open whether the client is still under the
// configured connection limit. Every event gives exactly one result. The block
// takes one event per clock cycle while its output is not stalled. An event is
// captured in an input register at its transfer; the table is searched in
// parallel and updated as the event moves to the output register, from which
// the result is presented. The result sits in the output register until it is
// taken. A stalled output holds the input register, and the input then stalls
// too. The associative search and count update over all slots set the rate.
// Counts reset to zero, so no clearing pass is needed.
module per_client_connection_limiter_top #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [cplim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cplim_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             kind,
	input  wire logic [cplim_pkg::ADDR_W-1:0]     client_addr,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  accepted,
	output logic [1:0]                            status,
	output logic [cplim_pkg::CNT_W-1:0]           live_count
);

	logic                         limit_enabled_q;
	logic [cplim_pkg::CNT_W-1:0]  conn_limit_q;

	logic                         valid_s1;
	logic                         kind_s1;
	logic [cplim_pkg::ADDR_W-1:0] addr_s1;

	logic                         out_valid_q;
	logic                         accepted_q;
	logic [1:0]                   status_q;
	logic [cplim_pkg::CNT_W-1:0]  live_count_q;

	logic                         load_s1;
	logic                         advance;

	cplim_pkg::lookup_t           look;
	cplim_pkg::update_t           upd;
	logic                         dec_accepted;
	cplim_pkg::status_t           dec_status;
	logic [cplim_pkg::CNT_W-1:0]  dec_live;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_enabled_q <= 1'b1;
			conn_limit_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cplim_pkg::CFG_LIMIT_ENABLED: limit_enabled_q <= cfg_data[0];
				cplim_pkg::CFG_MAX_CONN:      conn_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The table changes only on the cycle the event moves to the output register.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1 <= kind;
			addr_s1 <= client_addr;
		end
	end

	cplim_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (addr_s1),
		.upd    (upd),
		.look   (look)
	);

	cplim_decide u_decide (
		.fire          (advance),
		.kind          (kind_s1),
		.limit_enabled (limit_enabled_q),
		.conn_limit    (conn_limit_q),
		.look          (look),
		.upd           (upd),
		.accepted      (dec_accepted),
		.status        (dec_status),
		.live_count    (dec_live)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accepted_q   <= dec_accepted;
			status_q     <= dec_status;
			live_count_q <= dec_live;
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = accepted_q;
	assign status     = status_q;
	assign live_count = live_count_q;

endmodule

`default_nettype wire

@@ rtl/cplim_checker.sv @@
// Port-level checks for the per-client connection limiter, bound to the top level.
`default_nettype none

module cplim_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        accepted,
	input wire logic [1:0]                  status,
	input wire logic [cplim_pkg::CNT_W-1:0] live_count
);

	// A result waiting on a stall keeps all of its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accepted) && $stable(status)
			&& $stable(live_count))
	else $error("stalled result changed");

	// A refused or flagged event never reports the connection as accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> status == cplim_pkg::ST_OK)
	else $error("accepted result with nonzero status");

	// An address with no slot reports no live count.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == cplim_pkg::ST_TABLE_FULL || status == cplim_pkg::ST_NO_COUNT)
			|-> live_count == '0)
	else $error("live count reported for an address without a slot");

	// A refusal over the limit has still counted the connection.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cplim_pkg::ST_OVER_LIMIT |-> !accepted && live_count != '0)
	else $error("over-limit result without a count");

endmodule

bind per_client_connection_limiter_top cplim_checker u_cplim_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.accepted   (accepted),
	.status     (status),
	.live_count (live_count)
);

`default_nettype wire
